[hw/rtl/spremap_pkg.sv]
package spremap_pkg;

  // Field widths of the beats on the ports
  typedef logic [39:0] fpos_t;
  typedef logic [3:0]  sidx_t;
  typedef logic [9:0]  tidx_t;

  // Original position stored in a closing sentinel entry
  localparam logic [63:0] SENTINEL_ORIG = 64'd100000000000;

  typedef enum logic [1:0] {
    REQ_OPEN   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_CLAMPED  = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_NOSEG    = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_NOTFOUND = 3'd5,
    STAT_EMPTYTAB = 3'd6
  } stat_e;

  // Entry memory read address select
  typedef enum logic [1:0] {
    RD_END_M1 = 2'd0,
    RD_BASE   = 2'd1,
    RD_IDX_P1 = 2'd2
  } rd_sel_e;

  typedef struct packed {
    req_e  req_type;
    fpos_t source_size;
    fpos_t from_pos;
    fpos_t to_pos;
    logic  to_is_end;
    fpos_t query_pos;
  } remap_req_t;

  typedef struct packed {
    stat_e status;
    fpos_t original_pos;
    sidx_t segment_index;
    tidx_t transition_index;
    fpos_t virtual_total;
  } remap_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    take;
    logic    set_st;
    stat_e   st;
    logic    calc_top;
    logic    calc_diff;
    logic    append;
    logic    app_sent;
    logic    add_total;
    logic    open_seg;
    logic    lk_init;
    logic    seg_fetch;
    logic    seg_skip;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    t_init;
    logic    t_step;
    logic    cur_load;
    logic    calc_sub;
    logic    calc_fin;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_e req;
    logic sc_zero;
    logic sc_full;
    logic ec_zero;
    logic ec_full;
    logic total_zero;
    logic from_ge_top;
    logic diff_gt_room;
    logic seg_past;
    logic seg_empty;
    logic q_lt_rd;
    logic t_more;
    logic out_free;
  } dp_flags_t;

endpackage

[hw/rtl/spremap_ctrl.sv]
module spremap_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  spremap_pkg::dp_flags_t flags_i,
  output spremap_pkg::dp_cmd_t   cmd_o
);
  import spremap_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_DECODE     = 13'b0000000000010,
    S_OPEN_SET   = 13'b0000000000100,
    S_ADD_CHK    = 13'b0000000001000,
    S_ADD_COMMIT = 13'b0000000010000,
    S_LK_SEG     = 13'b0000000100000,
    S_LK_SEG_CHK = 13'b0000001000000,
    S_LK_SEG_CMP = 13'b0000010000000,
    S_LK_T_LOAD  = 13'b0000100000000,
    S_LK_T_NEXT  = 13'b0001000000000,
    S_LK_T_CMP   = 13'b0010000000000,
    S_LK_CALC    = 13'b0100000000000,
    S_RESP       = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // Take a new beat only between items
  assign in_stall_o = (state_q != S_IDLE);

  // Sequence one item through the datapath
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (flags_i.req)
          REQ_OPEN: begin
            if (flags_i.sc_full || (!flags_i.total_zero && flags_i.ec_full)) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = STAT_FULL;
              state_d      = S_RESP;
            end else begin
              // Close the previous segment with a sentinel first, if the total is nonzero
              cmd_o.append   = !flags_i.total_zero;
              cmd_o.app_sent = 1'b1;
              state_d        = S_OPEN_SET;
            end
          end
          REQ_ADD: begin
            if (flags_i.sc_zero) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = STAT_NOSEG;
              state_d      = S_RESP;
            end else begin
              cmd_o.calc_top = 1'b1;
              state_d        = S_ADD_CHK;
            end
          end
          REQ_FINISH: begin
            if (flags_i.total_zero || flags_i.sc_zero) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = STAT_EMPTYTAB;
            end else if (flags_i.ec_full) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = STAT_FULL;
            end else begin
              cmd_o.append   = 1'b1;
              cmd_o.app_sent = 1'b1;
            end
            state_d = S_RESP;
          end
          REQ_LOOKUP: begin
            if (flags_i.ec_zero) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = STAT_EMPTYTAB;
              state_d      = S_RESP;
            end else begin
              cmd_o.lk_init = 1'b1;
              state_d       = S_LK_SEG;
            end
          end
        endcase
      end
      S_OPEN_SET: begin
        cmd_o.open_seg = 1'b1;
        state_d        = S_RESP;
      end
      S_ADD_CHK: begin
        if (flags_i.from_ge_top) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = STAT_EMPTY;
          state_d      = S_RESP;
        end else begin
          cmd_o.calc_diff = 1'b1;
          state_d         = S_ADD_COMMIT;
        end
      end
      S_ADD_COMMIT: begin
        if (flags_i.ec_full || flags_i.diff_gt_room) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = STAT_FULL;
        end else begin
          cmd_o.append    = 1'b1;
          cmd_o.add_total = 1'b1;
        end
        state_d = S_RESP;
      end
      S_LK_SEG: begin
        if (flags_i.seg_past) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = STAT_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          cmd_o.seg_fetch = 1'b1;
          state_d         = S_LK_SEG_CHK;
        end
      end
      S_LK_SEG_CHK: begin
        if (flags_i.seg_empty) begin
          cmd_o.seg_skip = 1'b1;
          state_d        = S_LK_SEG;
        end else begin
          // Fetch the segment's last entry
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_END_M1;
          state_d      = S_LK_SEG_CMP;
        end
      end
      S_LK_SEG_CMP: begin
        if (flags_i.q_lt_rd) begin
          cmd_o.t_init = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_BASE;
          state_d      = S_LK_T_LOAD;
        end else begin
          cmd_o.seg_skip = 1'b1;
          state_d        = S_LK_SEG;
        end
      end
      S_LK_T_LOAD: begin
        cmd_o.cur_load = 1'b1;
        state_d        = S_LK_T_NEXT;
      end
      S_LK_T_NEXT: begin
        if (flags_i.t_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_P1;
          state_d      = S_LK_T_CMP;
        end else begin
          cmd_o.calc_sub = 1'b1;
          state_d        = S_LK_CALC;
        end
      end
      S_LK_T_CMP: begin
        if (!flags_i.q_lt_rd) begin
          cmd_o.t_step = 1'b1;
          state_d      = S_LK_T_NEXT;
        end else begin
          cmd_o.calc_sub = 1'b1;
          state_d        = S_LK_CALC;
        end
      end
      S_LK_CALC: begin
        cmd_o.calc_fin = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        // Hold the result until the output register is free
        if (flags_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/spremap_dp.sv]
module spremap_dp #(
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned MAX_ENTRIES  = 1024,
  parameter int unsigned POS_BITS     = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spremap_pkg::remap_req_t in_data_i,
  input  spremap_pkg::dp_cmd_t    cmd_i,
  output spremap_pkg::dp_flags_t  flags_o,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output spremap_pkg::remap_rsp_t out_data_o
);
  import spremap_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned ECW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned EW  = 2 * POS_BITS;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [ECW-1:0]      ecnt_t;
  typedef logic [SCW-1:0]      scnt_t;

  // Item and table bookkeeping
  remap_req_t item_q;
  scnt_t      sc_q;
  ecnt_t      ec_q;
  pos_t       total_q;
  pos_t       src_q;
  ecnt_t      seg_end_q [MAX_SEGMENTS];

  // Entry memory: {original start, virtual start}
  logic [EW-1:0] mem [MAX_ENTRIES];
  logic [EW-1:0] rdata_q;

  // Working registers
  pos_t          top_q;
  pos_t          diff_q;
  scnt_t         s_q;
  ecnt_t         base_q;
  ecnt_t         end_q;
  ecnt_t         idx_q;
  logic [AW-1:0] t_q;
  logic [EW-1:0] cur_q;
  pos_t          acc_q;

  // Result registers
  stat_e      st_q;
  fpos_t      opos_q;
  sidx_t      sidx_q;
  tidx_t      tidx_q;
  remap_rsp_t out_q;
  logic       out_valid_q;

  pos_t          src_p, from_p, to_p, q_p, orig_w;
  scnt_t         sc_last;
  ecnt_t         ec_inc, idx_p1, end_m1, rd_addr;
  logic          clamp;

  assign src_p   = POS_BITS'(item_q.source_size);
  assign from_p  = POS_BITS'(item_q.from_pos);
  assign to_p    = POS_BITS'(item_q.to_pos);
  assign q_p     = POS_BITS'(item_q.query_pos);
  assign orig_w  = cmd_i.app_sent ? POS_BITS'(SENTINEL_ORIG) : from_p;
  assign sc_last = sc_q - scnt_t'(1);
  assign ec_inc  = ec_q + ecnt_t'(1);
  assign idx_p1  = idx_q + ecnt_t'(1);
  assign end_m1  = end_q - ecnt_t'(1);
  assign clamp   = !item_q.to_is_end && (to_p > src_q);

  // Select the entry read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_END_M1: rd_addr = end_m1;
      RD_BASE:   rd_addr = base_q;
      RD_IDX_P1: rd_addr = idx_p1;
      default:   rd_addr = base_q;
    endcase
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_q <= in_data_i;
    end
  end

  // Table counters and running total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q    <= '0;
      ec_q    <= '0;
      total_q <= '0;
      src_q   <= '0;
    end else begin
      if (cmd_i.append) begin
        ec_q <= ec_inc;
      end
      if (cmd_i.add_total) begin
        total_q <= total_q + diff_q;
      end
      if (cmd_i.open_seg) begin
        sc_q  <= sc_q + scnt_t'(1);
        src_q <= src_p;
      end
    end
  end

  // Segment end indices: grow the last segment, or start a new one
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      seg_end_q[sc_last[SAW-1:0]] <= ec_inc;
    end else if (cmd_i.open_seg) begin
      seg_end_q[sc_q[SAW-1:0]] <= ec_q;
    end
  end

  // Entry memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[ec_q[AW-1:0]] <= {orig_w, total_q};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr[AW-1:0]];
    end
  end

  // Transition end and length
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_top) begin
      top_q <= (item_q.to_is_end || clamp) ? src_q : to_p;
    end
    if (cmd_i.calc_diff) begin
      diff_q <= top_q - from_p;
    end
  end

  // Lookup walk over segments and transitions
  always_ff @(posedge clk_i) begin
    if (cmd_i.lk_init) begin
      s_q    <= '0;
      base_q <= '0;
    end else if (cmd_i.seg_skip) begin
      s_q    <= s_q + scnt_t'(1);
      base_q <= end_q;
    end
    if (cmd_i.seg_fetch) begin
      end_q <= seg_end_q[s_q[SAW-1:0]];
    end
    if (cmd_i.t_init) begin
      idx_q <= base_q;
      t_q   <= '0;
    end else if (cmd_i.t_step) begin
      idx_q <= idx_p1;
      t_q   <= t_q + AW'(1);
    end
    if (cmd_i.cur_load || cmd_i.t_step) begin
      cur_q <= rdata_q;
    end
    if (cmd_i.calc_sub) begin
      acc_q <= q_p - cur_q[POS_BITS-1:0];
    end
  end

  // Result fields of the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      st_q   <= STAT_OK;
      opos_q <= '0;
      sidx_q <= '0;
      tidx_q <= '0;
    end else begin
      if (cmd_i.set_st) begin
        st_q <= cmd_i.st;
      end else if (cmd_i.calc_top && clamp) begin
        st_q <= STAT_CLAMPED;
      end
      if (cmd_i.calc_fin) begin
        opos_q <= fpos_t'(pos_t'(acc_q + cur_q[EW-1:POS_BITS]));
        sidx_q <= sidx_t'(s_q);
        tidx_q <= tidx_t'(t_q);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status           <= st_q;
      out_q.original_pos     <= opos_q;
      out_q.segment_index    <= sidx_q;
      out_q.transition_index <= tidx_q;
      out_q.virtual_total    <= fpos_t'(total_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status toward the controller
  assign flags_o.req          = item_q.req_type;
  assign flags_o.sc_zero      = (sc_q == '0);
  assign flags_o.sc_full      = (sc_q == scnt_t'(MAX_SEGMENTS));
  assign flags_o.ec_zero      = (ec_q == '0);
  assign flags_o.ec_full      = (ec_q == ecnt_t'(MAX_ENTRIES));
  assign flags_o.total_zero   = (total_q == '0);
  assign flags_o.from_ge_top  = (from_p >= top_q);
  assign flags_o.diff_gt_room = (diff_q > ~total_q);
  assign flags_o.seg_past     = (s_q == sc_q);
  assign flags_o.seg_empty    = (end_q == base_q);
  assign flags_o.q_lt_rd      = (q_p < rdata_q[POS_BITS-1:0]);
  assign flags_o.t_more       = (idx_p1 < end_q);
  assign flags_o.out_free     = !out_valid_q || !out_stall_i;

endmodule

[hw/rtl/segment_position_remap_table_core.sv]
// Segment position remap table.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one request beat:
// open segment, add transition, finish table or lookup. Output channel
// (out_valid_o / out_stall_i / out_data_o) returns exactly one result beat per
// request, in request order.
// One item is worked at a time. A lookup walks the segments, skipping empty
// ones and those that end at or below the query, then steps through the
// transitions of the hit segment; a miss walks every segment. The walk is set
// by the single read port of the entry memory, one registered read per step.
// A new beat is accepted as soon as the previous result sits in the output
// register, even if the receiver still stalls it. While out_stall_i is high
// the result beat holds; a finished item then waits and in_stall_o stays high.
// Reset clears the table (no segments, no entries, total zero) at once; no
// clearing pass runs and the first beat can be accepted right after reset.
module segment_position_remap_table_core #(
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned MAX_ENTRIES  = 1024,
  parameter int unsigned POS_BITS     = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  spremap_pkg::remap_req_t in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output spremap_pkg::remap_rsp_t out_data_o
);
  import spremap_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  spremap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  spremap_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_ENTRIES  (MAX_ENTRIES),
    .POS_BITS     (POS_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/spremap_chk.sv]
module spremap_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input spremap_pkg::remap_req_t in_data_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input spremap_pkg::remap_rsp_t out_data_o
);
  import spremap_pkg::*;

  // An accepted beat keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A new result beat only appears at the end of item work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without item work");

  // Only a lookup hit reports a position
  a_miss_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STAT_OK) |->
      (out_data_o.original_pos == '0) && (out_data_o.segment_index == '0) &&
      (out_data_o.transition_index == '0))
    else $error("non-ok result carries lookup fields");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

endmodule

bind segment_position_remap_table_core spremap_chk u_spremap_chk (.*);

[dv/tb.sv]
module tb;
  import spremap_pkg::*;

  localparam int    NSEG        = 16;
  localparam int    NENT        = 1024;
  localparam fpos_t POS_MAX     = '1;
  localparam int    IDLE_PCT    = 19;
  localparam int    QUIET_LO    = 300;
  localparam int    QUIET_HI    = 500;
  localparam int    HOLD_AT     = 700;
  localparam int    HOLD_LEN    = 300;
  localparam int    DRAIN_AT    = 900;
  localparam int    STALL_LIMIT = 20000;
  localparam int    SETTLE      = 50;
  localparam int    TAIL_OPS    = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  remap_req_t in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  remap_rsp_t out_data;

  segment_position_remap_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the remap table
  fpos_t tbl_orig [NENT];
  fpos_t tbl_virt [NENT];
  int    tbl_seg_first [NSEG];
  int    tbl_seg_len [NSEG];
  fpos_t tbl_src = '0;
  fpos_t tbl_total = '0;
  int    tbl_segs = 0;
  int    tbl_ents = 0;

  // Both queues fill at the front and drain from the back
  remap_req_t table_ops_q [$];
  remap_rsp_t remap_answer_q [$];
  remap_rsp_t want;

  int n_in = 0;
  int n_out = 0;
  int n_bad = 0;
  int n_items = 0;
  int deepest_tr = 0;
  int st_count [8] = '{default: 0};
  int quiet_cycles = 0;
  int hold_left = 0;
  logic held = 1'b0;

  // Generator view of the table, enough to keep most beats well formed
  fpos_t gen_src;
  fpos_t gen_total;
  int    gen_segs;
  int    gen_est;

  wire in_beat  = in_valid && !in_stall;
  wire out_beat = out_valid && !out_stall;
  int sent;
  assign sent = n_in + int'(in_beat);
  wire in_quiet = sent >= QUIET_LO && sent < QUIET_HI;

  function automatic void store_entry(fpos_t orig, fpos_t virt);
    tbl_orig[tbl_ents] = orig;
    tbl_virt[tbl_ents] = virt;
    tbl_ents++;
    tbl_seg_len[tbl_segs - 1]++;
  endfunction

  // Apply one request to the shadow table and return the result beat it yields
  function automatic remap_rsp_t remap_table_step(remap_req_t r);
    remap_rsp_t e;
    fpos_t top;
    int s, t, f, c;
    logic hit;
    e = '0;
    e.status = STAT_OK;
    case (r.req_type)
      REQ_OPEN: begin
        if (tbl_segs >= NSEG || (tbl_total != 0 && tbl_ents >= NENT)) begin
          e.status = STAT_FULL;
        end else begin
          if (tbl_total != 0) store_entry(fpos_t'(SENTINEL_ORIG), tbl_total);
          tbl_seg_first[tbl_segs] = tbl_ents;
          tbl_seg_len[tbl_segs] = 0;
          tbl_segs++;
          tbl_src = r.source_size;
        end
      end
      REQ_ADD: begin
        if (tbl_segs == 0) begin
          e.status = STAT_NOSEG;
        end else begin
          if (r.to_is_end) begin
            top = tbl_src;
          end else if (r.to_pos > tbl_src) begin
            top = tbl_src;
            e.status = STAT_CLAMPED;
          end else begin
            top = r.to_pos;
          end
          if (r.from_pos >= top) begin
            e.status = STAT_EMPTY;
          end else if (tbl_ents >= NENT || (top - r.from_pos) > (POS_MAX - tbl_total)) begin
            e.status = STAT_FULL;
          end else begin
            store_entry(r.from_pos, tbl_total);
            tbl_total = tbl_total + (top - r.from_pos);
          end
        end
      end
      REQ_FINISH: begin
        if (tbl_total == 0 || tbl_segs == 0) e.status = STAT_EMPTYTAB;
        else if (tbl_ents >= NENT) e.status = STAT_FULL;
        else store_entry(fpos_t'(SENTINEL_ORIG), tbl_total);
      end
      default: begin
        if (tbl_ents == 0) begin
          e.status = STAT_EMPTYTAB;
        end else begin
          // skip empty segments and those that end at or below the query
          s = 0;
          hit = 1'b0;
          while (!hit && s < tbl_segs) begin
            c = tbl_seg_len[s];
            f = tbl_seg_first[s];
            if (c != 0) begin
              if (r.query_pos < tbl_virt[f + c - 1]) hit = 1'b1;
            end
            if (!hit) s++;
          end
          if (!hit) begin
            e.status = STAT_NOTFOUND;
          end else begin
            t = 0;
            while (t + 1 < c && r.query_pos >= tbl_virt[f + t + 1]) t++;
            e.original_pos = r.query_pos - tbl_virt[f + t] + tbl_orig[f + t];
            e.segment_index = sidx_t'(s);
            e.transition_index = tidx_t'(t);
          end
        end
      end
    endcase
    e.virtual_total = tbl_total;
    return e;
  endfunction

  function automatic fpos_t any_pos();
    return fpos_t'({$urandom, $urandom});
  endfunction

  function automatic fpos_t pos_below(fpos_t n);
    return fpos_t'({$urandom, $urandom} % {24'd0, n});
  endfunction

  function automatic remap_req_t op_beat(req_e k, fpos_t src, fpos_t from, fpos_t to,
                                         logic te, fpos_t q);
    remap_req_t r;
    r.req_type = k;
    r.source_size = src;
    r.from_pos = from;
    r.to_pos = to;
    r.to_is_end = te;
    r.query_pos = q;
    return r;
  endfunction

  // Drive request beats; predict each one as it is accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_beat) begin
        remap_answer_q.push_front(remap_table_step(in_data));
        n_in <= n_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (table_ops_q.size() != 0 && !(sent == DRAIN_AT && n_out != sent) &&
            (in_quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_data <= table_ops_q.pop_back();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall result beats at random, with one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= hold_left > 1;
    end else if (!held && n_out >= HOLD_AT) begin
      held <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(n_out >= QUIET_LO && n_out < QUIET_HI) &&
                   ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_beat) begin
      n_out <= n_out + 1;
      if (remap_answer_q.size() == 0) begin
        if (n_bad < 10)
          $display("unexpected result beat: st=%0d pos=%0h tot=%0h",
                   out_data.status, out_data.original_pos, out_data.virtual_total);
        n_bad <= n_bad + 1;
      end else begin
        want = remap_answer_q.pop_back();
        st_count[want.status] <= st_count[want.status] + 1;
        if (int'(want.transition_index) > deepest_tr)
          deepest_tr <= int'(want.transition_index);
        if (out_data.status !== want.status || out_data.original_pos !== want.original_pos ||
            out_data.segment_index !== want.segment_index ||
            out_data.transition_index !== want.transition_index ||
            out_data.virtual_total !== want.virtual_total) begin
          if (n_bad < 10)
            $display("beat %0d: want st=%0d pos=%0h seg=%0d tr=%0d tot=%0h", n_out,
                     want.status, want.original_pos, want.segment_index,
                     want.transition_index, want.virtual_total);
          if (n_bad < 10)
            $display("         got  st=%0d pos=%0h seg=%0d tr=%0d tot=%0h",
                     out_data.status, out_data.original_pos, out_data.segment_index,
                     out_data.transition_index, out_data.virtual_total);
          n_bad <= n_bad + 1;
        end
      end
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_beat || out_beat) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d request and %0d result beats", n_in, n_out);
        $display("tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int   tail;
    int   pick;
    int   sel;
    fpos_t span;
    remap_req_t op;

    // Directed: empty table, zero-size segment, extremes, clamping, open segment end
    table_ops_q.push_front(op_beat(REQ_LOOKUP, '0, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, '0, 40'd10, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_FINISH, '0, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_OPEN, '0, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, '0, 40'd5, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, '0, '0, 1'b1, '0));
    table_ops_q.push_front(op_beat(REQ_FINISH, '0, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_LOOKUP, '0, '0, '0, 1'b0, POS_MAX));
    table_ops_q.push_front(op_beat(REQ_OPEN, POS_MAX, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, '0, 40'd100, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, POS_MAX - 40'd10, '0, 1'b1, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, 40'd5, 40'd5, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, '0, POS_MAX, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, 40'd1000, 40'd2000, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_LOOKUP, '0, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_LOOKUP, '0, '0, '0, 1'b0, 40'd105));
    table_ops_q.push_front(op_beat(REQ_LOOKUP, '0, '0, '0, 1'b0, 40'd110));
    table_ops_q.push_front(op_beat(REQ_FINISH, '0, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_LOOKUP, '0, '0, '0, 1'b0, 40'd1109));
    table_ops_q.push_front(op_beat(REQ_FINISH, '0, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_OPEN, 40'd50, '0, '0, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, 40'd10, 40'd60, 1'b0, '0));
    table_ops_q.push_front(op_beat(REQ_ADD, '0, 40'd60, '0, 1'b1, '0));
    table_ops_q.push_front(op_beat(REQ_LOOKUP, '0, '0, '0, 1'b0, 40'd1120));
    table_ops_q.push_front(op_beat(REQ_LOOKUP, '0, '0, '0, 1'b0, POS_MAX));
    gen_src = 40'd50;
    gen_total = 40'd1150;
    gen_segs = 3;
    gen_est = 7;

    // Random: mostly well-formed adds, run past the point the entry store fills
    tail = 0;
    while (tail < TAIL_OPS) begin
      if (gen_est >= NENT) tail++;
      pick = $urandom_range(0, 99);
      op = op_beat(REQ_LOOKUP, any_pos(), any_pos(), any_pos(), 1'($urandom_range(0, 1)),
                   any_pos());
      if (pick < 3) begin
        // open, mostly small segments, some at full width
        op.req_type = REQ_OPEN;
        sel = $urandom_range(0, 19);
        if (sel == 0) op.source_size = '0;
        else if (sel < 17) op.source_size = fpos_t'($urandom_range(1, 1 << 20));
        if (gen_segs < NSEG) begin
          gen_segs++;
          gen_src = op.source_size;
          gen_est++;
        end
      end else if (pick < 6) begin
        op.req_type = REQ_FINISH;
        gen_est++;
      end else if (pick < 16) begin
        // aim most lookups inside the table, some at its end
        sel = $urandom_range(0, 9);
        if (sel < 6) op.query_pos = pos_below(gen_total);
        else if (sel < 8) op.query_pos = gen_total - fpos_t'(32) +
                                         fpos_t'($urandom_range(0, 64));
      end else if (pick < 95 && gen_src != 0) begin
        op.req_type = REQ_ADD;
        op.to_is_end = 1'b0;
        span = fpos_t'($urandom_range(1, 4096));
        if (span > gen_src) span = gen_src;
        op.from_pos = pos_below(gen_src - span + fpos_t'(1));
        op.to_pos = op.from_pos + span;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
          // end taken from the segment size
          op.from_pos = gen_src - span;
          op.to_pos = any_pos();
          op.to_is_end = 1'b1;
        end else if (sel == 2) begin
          // end past the segment size, clamped back
          op.from_pos = gen_src - span;
          op.to_pos = (gen_src > POS_MAX - fpos_t'(4096)) ? POS_MAX :
                      gen_src + fpos_t'($urandom_range(1, 4096));
        end
        gen_total += span;
        gen_est++;
      end else begin
        // noise beat; keep it from eating the total in a wide segment
        op.req_type = req_e'($urandom_range(0, 3));
        if (op.req_type == REQ_ADD && gen_src > fpos_t'(1 << 24)) begin
          op.to_pos = op.from_pos;
          op.to_is_end = 1'b0;
        end
        if (op.req_type == REQ_OPEN && gen_segs < NSEG) begin
          gen_segs++;
          gen_src = op.source_size;
        end
      end
      table_ops_q.push_front(op);
    end
    n_items = table_ops_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_in == n_items && n_out >= n_items);
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d request beats, deepest transition %0d", n_items, deepest_tr);
    $display("ok %0d clamped %0d empty %0d noseg %0d full %0d notfound %0d emptytab %0d",
             st_count[STAT_OK], st_count[STAT_CLAMPED], st_count[STAT_EMPTY],
             st_count[STAT_NOSEG], st_count[STAT_FULL], st_count[STAT_NOTFOUND],
             st_count[STAT_EMPTYTAB]);
    if (n_bad == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
